FILE: rtl/core/hrhe_pkg.sv
// Shared types, codes and constants for the HTTP request host extractor.
// Used by hrhe_parse and http_request_host_extractor; depends on nothing.
`default_nettype none

package hrhe_pkg;

  // Field widths of one input item and one result item.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TagW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 3;

  // Packed stream widths: the result data carries byte and status, padded to bytes.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  // Number of characters in the header name that is searched for.
  localparam logic [CountW-1:0] NameLen = 3'd4;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_METHOD_START = 4'd0,
    PH_METHOD       = 4'd1,
    PH_GAP          = 4'd2,
    PH_PATH         = 4'd3,
    PH_REST         = 4'd4,
    PH_NAME         = 4'd5,
    PH_SKIP_LINE    = 4'd6,
    PH_VALUE_BLANK  = 4'd7,
    PH_VALUE        = 4'd8
  } phase_t;

  // Tag on a passed-through byte.
  typedef enum logic [TagW-1:0] {
    TAG_NONE   = 2'd0,
    TAG_METHOD = 2'd1,
    TAG_PATH   = 2'd2,
    TAG_HOST   = 2'd3
  } tag_t;

  // Outcome of a request.
  typedef enum logic [StatusW-1:0] {
    ST_PENDING = 2'd0,
    ST_FOUND   = 2'd1,
    ST_REJECT  = 2'd2
  } status_t;

  // Character constants.
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChVt    = 8'h0B;
  localparam logic [ByteW-1:0] ChFf    = 8'h0C;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;

  // One input item.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    tag_t             tag;
    logic [ByteW-1:0] data;
    status_t          status;
  } result_t;

  // Characters of the header name "Host", indexed from the first.
  function automatic logic [ByteW-1:0] host_char(input logic [1:0] idx);
    logic [ByteW-1:0] ch;
    case (idx)
      2'd0:    ch = 8'h48;
      2'd1:    ch = 8'h6F;
      2'd2:    ch = 8'h73;
      2'd3:    ch = 8'h74;
      default: ch = 8'h48;
    endcase
    return ch;
  endfunction

  function automatic logic is_newline(input logic [ByteW-1:0] b);
    return (b == ChLf) || (b == ChCr);
  endfunction

  function automatic logic is_white(input logic [ByteW-1:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChLf) || (b == ChVt) ||
           (b == ChFf) || (b == ChCr);
  endfunction

  function automatic logic is_line_end(input logic [ByteW-1:0] b);
    return is_newline(b) || (b == ChNul);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/http_request_host_extractor.sv
// Channel   | Dir | Transfer fields
// in_       | in  | tdata[7:0] data_byte, tlast last_byte
// out_      | out | tuser[1:0] field_tag, tdata[7:0] out_byte, tdata[9:8] status
//
// Each byte gives one result. A byte is registered in the input register on acceptance,
// decoded combinationally against the parser state and loaded into the result register,
// from which its result is offered; one byte per cycle is sustained while the result
// side does not stall.
// Reset (rst_n low, synchronous) empties both registers and rearms the parser.
// A stall on the result side holds the result register and then the input register;
// in_tready follows out_tready combinationally through the two stages.
// Top level of the HTTP request host extractor; depends on hrhe_pkg and hrhe_parse.
`default_nettype none

module http_request_host_extractor (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [hrhe_pkg::InDataW-1:0]      in_tdata,   // [7:0] data_byte
  input  wire                               in_tlast,   // last_byte
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [hrhe_pkg::OutDataW-1:0]     out_tdata,  // [7:0] out_byte, [9:8] status
  output logic [hrhe_pkg::TagW-1:0]         out_tuser   // [1:0] field_tag
);

  logic                 in_valid_r;
  hrhe_pkg::item_t      in_item_r;
  logic                 out_valid_r;
  hrhe_pkg::result_t    out_res_r;
  hrhe_pkg::result_t    res;
  logic                 out_load;
  logic                 in_load;

  // The result register takes a new item when empty or being drained.
  assign out_load  = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || out_load;
  assign in_load   = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_item_r.data_byte <= in_tdata[hrhe_pkg::ByteW-1:0];
      in_item_r.last_byte <= in_tlast;
    end
  end

  // Per-byte decode against the parser state.
  hrhe_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (out_load),
    .item  (in_item_r),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.tag;
  assign out_tdata  = {{(hrhe_pkg::OutDataW - hrhe_pkg::ByteW - hrhe_pkg::StatusW){1'b0}},
                       out_res_r.status, out_res_r.data};

  // A held input item keeps its contents while the result side stalls.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_load |=> in_valid_r && $stable(in_item_r))
    else $error("http_request_host_extractor: input register lost an item");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !out_load)
    else $error("http_request_host_extractor: result overwritten");

  // Untagged results carry a zero byte.
  a_zero_untagged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.tag == hrhe_pkg::TAG_NONE) |-> (out_res_r.data == '0))
    else $error("http_request_host_extractor: byte on untagged result");

endmodule

`default_nettype wire

FILE: rtl/core/hrhe_parse.sv
// Parser state and per-byte decode logic for the HTTP request host extractor.
// Depends on hrhe_pkg for phases, codes, character tests and item/result types.
`default_nettype none

module hrhe_parse (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step,     // the item is handed on this cycle
  input  wire hrhe_pkg::item_t item,
  output hrhe_pkg::result_t   res
);

  hrhe_pkg::phase_t                  phase_r,     phase_nxt;
  logic [hrhe_pkg::CountW-1:0]       match_cnt_r, match_cnt_nxt;
  logic                              match_ok_r,  match_ok_nxt;
  logic                              decided_r,   decided_nxt;

  logic [hrhe_pkg::ByteW-1:0]        b;
  logic                              last;
  hrhe_pkg::tag_t                    tag;
  hrhe_pkg::status_t                 status;
  logic                              name_hit;

  assign b    = item.data_byte;
  assign last = item.last_byte;

  // The next name character matches while the name still agrees with "Host".
  assign name_hit = match_ok_r && (match_cnt_r < hrhe_pkg::NameLen) &&
                    (b == hrhe_pkg::host_char(match_cnt_r[1:0]));

  // Decode one byte: phase transition, tag and status.
  always_comb begin
    phase_nxt     = phase_r;
    match_cnt_nxt = match_cnt_r;
    match_ok_nxt  = match_ok_r;
    decided_nxt   = decided_r;
    tag           = hrhe_pkg::TAG_NONE;
    status        = hrhe_pkg::ST_PENDING;

    if (!decided_r) begin
      case (phase_r)
        hrhe_pkg::PH_METHOD_START: begin
          if (hrhe_pkg::is_white(b)) begin
            status = hrhe_pkg::ST_REJECT;
          end else begin
            tag       = hrhe_pkg::TAG_METHOD;
            phase_nxt = hrhe_pkg::PH_METHOD;
          end
        end
        hrhe_pkg::PH_METHOD: begin
          if (hrhe_pkg::is_newline(b)) begin
            status = hrhe_pkg::ST_REJECT;
          end else if (hrhe_pkg::is_white(b)) begin
            phase_nxt = hrhe_pkg::PH_GAP;
          end else begin
            tag = hrhe_pkg::TAG_METHOD;
          end
        end
        hrhe_pkg::PH_GAP: begin
          if (hrhe_pkg::is_newline(b)) begin
            status = hrhe_pkg::ST_REJECT;
          end else if (!hrhe_pkg::is_white(b)) begin
            tag       = hrhe_pkg::TAG_PATH;
            phase_nxt = hrhe_pkg::PH_PATH;
          end
        end
        hrhe_pkg::PH_PATH: begin
          if (hrhe_pkg::is_newline(b)) begin
            status = hrhe_pkg::ST_REJECT;
          end else if (hrhe_pkg::is_white(b)) begin
            phase_nxt = hrhe_pkg::PH_REST;
          end else begin
            tag = hrhe_pkg::TAG_PATH;
          end
        end
        hrhe_pkg::PH_REST: begin
          if (hrhe_pkg::is_newline(b)) begin
            match_cnt_nxt = '0;
            match_ok_nxt  = 1'b1;
            phase_nxt     = hrhe_pkg::PH_NAME;
          end
        end
        hrhe_pkg::PH_NAME: begin
          if (hrhe_pkg::is_line_end(b)) begin
            match_cnt_nxt = '0;
            match_ok_nxt  = 1'b1;
          end else if (b == hrhe_pkg::ChColon) begin
            if (match_ok_r && (match_cnt_r == hrhe_pkg::NameLen)) begin
              phase_nxt = hrhe_pkg::PH_VALUE_BLANK;
            end else begin
              phase_nxt = hrhe_pkg::PH_SKIP_LINE;
            end
          end else if (name_hit) begin
            match_cnt_nxt = match_cnt_r + 3'd1;
          end else begin
            match_ok_nxt = 1'b0;
          end
        end
        hrhe_pkg::PH_SKIP_LINE: begin
          if (hrhe_pkg::is_line_end(b)) begin
            match_cnt_nxt = '0;
            match_ok_nxt  = 1'b1;
            phase_nxt     = hrhe_pkg::PH_NAME;
          end
        end
        hrhe_pkg::PH_VALUE_BLANK: begin
          if (hrhe_pkg::is_line_end(b)) begin
            status = hrhe_pkg::ST_FOUND;
          end else if (!hrhe_pkg::is_white(b)) begin
            tag       = hrhe_pkg::TAG_HOST;
            phase_nxt = hrhe_pkg::PH_VALUE;
          end
        end
        hrhe_pkg::PH_VALUE: begin
          if (hrhe_pkg::is_line_end(b)) begin
            status = hrhe_pkg::ST_FOUND;
          end else begin
            tag = hrhe_pkg::TAG_HOST;
          end
        end
        default: begin
          status = hrhe_pkg::ST_REJECT;
        end
      endcase

      // The last byte forces a decision: success only inside the host value.
      if (last && (status == hrhe_pkg::ST_PENDING)) begin
        if ((phase_nxt == hrhe_pkg::PH_VALUE_BLANK) || (phase_nxt == hrhe_pkg::PH_VALUE)) begin
          status = hrhe_pkg::ST_FOUND;
        end else begin
          status = hrhe_pkg::ST_REJECT;
        end
      end

      if (status != hrhe_pkg::ST_PENDING) begin
        decided_nxt = 1'b1;
      end
    end

    // The last byte of a buffer rearms the parser.
    if (last) begin
      phase_nxt     = hrhe_pkg::PH_METHOD_START;
      match_cnt_nxt = '0;
      match_ok_nxt  = 1'b1;
      decided_nxt   = 1'b0;
    end

    res.tag    = tag;
    res.data   = (tag != hrhe_pkg::TAG_NONE) ? b : '0;
    res.status = status;
  end

  // Parser state advances only when an item is handed on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hrhe_pkg::PH_METHOD_START;
      match_cnt_r <= '0;
      match_ok_r  <= 1'b1;
      decided_r   <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      match_cnt_r <= match_cnt_nxt;
      match_ok_r  <= match_ok_nxt;
      decided_r   <= decided_nxt;
    end
  end

  // Once decided, bytes pass silently until the buffer ends.
  a_quiet_after_decision: assert property (@(posedge clk) disable iff (!rst_n)
    step && decided_r |-> (res.tag == hrhe_pkg::TAG_NONE) && (res.status == hrhe_pkg::ST_PENDING))
    else $error("hrhe_parse: output after decision");

  // A last byte always leaves the parser rearmed.
  a_rearm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> (phase_r == hrhe_pkg::PH_METHOD_START) && !decided_r &&
                     (match_cnt_r == '0) && match_ok_r)
    else $error("hrhe_parse: not rearmed after last byte");

  // A last byte that is not already past a decision always reports an outcome.
  a_last_decides: assert property (@(posedge clk) disable iff (!rst_n)
    step && last && !decided_r |-> (res.status != hrhe_pkg::ST_PENDING))
    else $error("hrhe_parse: buffer ended without a status");

  // The name match count never runs past the name length.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    match_cnt_r <= hrhe_pkg::NameLen)
    else $error("hrhe_parse: name match count out of range");

endmodule

`default_nettype wire

FILE: verif/http_request_host_extractor_check.sv
// Checker for the HTTP request host extractor: watches both stream channels,
// predicts each result from the accepted bytes and compares field by field.
// Depends on hrhe_pkg for the tag and status codes and the character constants.
module http_request_host_extractor_check
  import hrhe_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  input  wire                 in_tready,
  input  wire  [InDataW-1:0]  in_tdata,    // [7:0] data_byte
  input  wire                 in_tlast,    // last_byte
  input  wire                 out_tvalid,
  input  wire                 out_tready,
  input  wire  [OutDataW-1:0] out_tdata,   // [7:0] out_byte, [9:8] status
  input  wire  [TagW-1:0]     out_tuser,   // [1:0] field_tag
  output int                  fail_count,
  output int                  outstanding,
  output int                  result_count,
  output int                  found_count,
  output int                  reject_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Header name searched for, first character in the top byte.
  localparam logic [31:0] HostName = "Host";

  // Predictor state, mirrored from the parser.
  phase_t           parse_state;
  logic [CountW-1:0] name_hits;
  logic             name_ok;
  logic             decided;

  result_t expected_results[$];

  function automatic logic is_blank_byte(input logic [ByteW-1:0] b);
    case (b)
      ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic ends_request_line(input logic [ByteW-1:0] b);
    return (b == ChCr) || (b == ChLf);
  endfunction

  function automatic logic ends_header_line(input logic [ByteW-1:0] b);
    return (b == ChCr) || (b == ChLf) || (b == ChNul);
  endfunction

  function automatic void start_header_line();
    name_hits = '0;
    name_ok = 1'b1;
  endfunction

  function automatic void restart_request();
    parse_state = PH_METHOD_START;
    start_header_line();
    decided = 1'b0;
  endfunction

  // Works out the result of one byte and advances the predicted parser state.
  function automatic result_t parse_byte(input logic [ByteW-1:0] b, input logic last);
    result_t r;
    r.tag = TAG_NONE;
    r.data = '0;
    r.status = ST_PENDING;
    if (decided) begin
      if (last) restart_request();
      return r;
    end
    case (parse_state)
      PH_METHOD_START: begin
        if (is_blank_byte(b)) begin
          r.status = ST_REJECT;
        end else begin
          r.tag = TAG_METHOD;
          parse_state = PH_METHOD;
        end
      end
      PH_METHOD: begin
        if (ends_request_line(b)) r.status = ST_REJECT;
        else if (is_blank_byte(b)) parse_state = PH_GAP;
        else r.tag = TAG_METHOD;
      end
      PH_GAP: begin
        if (ends_request_line(b)) begin
          r.status = ST_REJECT;
        end else if (!is_blank_byte(b)) begin
          r.tag = TAG_PATH;
          parse_state = PH_PATH;
        end
      end
      PH_PATH: begin
        if (ends_request_line(b)) r.status = ST_REJECT;
        else if (is_blank_byte(b)) parse_state = PH_REST;
        else r.tag = TAG_PATH;
      end
      PH_REST: begin
        if (ends_request_line(b)) begin
          start_header_line();
          parse_state = PH_NAME;
        end
      end
      PH_NAME: begin
        if (ends_header_line(b)) begin
          start_header_line();
        end else if (b == ChColon) begin
          parse_state = (name_ok && name_hits == NameLen) ? PH_VALUE_BLANK : PH_SKIP_LINE;
        end else if (name_ok && name_hits < NameLen &&
                     b == HostName[8*(3-name_hits[1:0]) +: 8]) begin
          name_hits = name_hits + 1'b1;
        end else begin
          name_ok = 1'b0;
        end
      end
      PH_SKIP_LINE: begin
        if (ends_header_line(b)) begin
          start_header_line();
          parse_state = PH_NAME;
        end
      end
      PH_VALUE_BLANK: begin
        if (ends_header_line(b)) begin
          r.status = ST_FOUND;
        end else if (!is_blank_byte(b)) begin
          r.tag = TAG_HOST;
          parse_state = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (ends_header_line(b)) r.status = ST_FOUND;
        else r.tag = TAG_HOST;
      end
      default: r.status = ST_REJECT;
    endcase

    // The last byte forces a decision: success only inside the host value.
    if (last && r.status == ST_PENDING) begin
      if (parse_state == PH_VALUE_BLANK || parse_state == PH_VALUE) r.status = ST_FOUND;
      else r.status = ST_REJECT;
    end
    if (r.status != ST_PENDING) decided = 1'b1;
    if (last) restart_request();
    if (r.tag != TAG_NONE) r.data = b;
    return r;
  endfunction

  // Predict on each input transfer, compare on each result transfer.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      restart_request();
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
      found_count = 0;
      reject_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        want = parse_byte(in_tdata[7:0], in_tlast);
        if (want.status == ST_FOUND) found_count++;
        if (want.status == ST_REJECT) reject_count++;
        expected_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.tag = tag_t'(out_tuser);
        got.data = out_tdata[7:0];
        got.status = status_t'(out_tdata[9:8]);
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing expected: tag %0d byte %02h status %0d",
                     $realtime, got.tag, got.data, got.status);
        end else begin
          want = expected_results.pop_front();
          result_count++;
          if (got.tag !== want.tag || got.data !== want.data || got.status !== want.status)
          begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result %0d: expected tag %0d byte %02h status %0d, ",
                       $realtime, result_count, want.tag, want.data, want.status,
                       "got tag %0d byte %02h status %0d",
                       got.tag, got.data, got.status);
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: verif/http_request_host_extractor_test.sv
// Top of the HTTP request host extractor test: clock, reset, request streams with
// random idling on both channels, and the verdict.
// Depends on hrhe_pkg, http_request_host_extractor and http_request_host_extractor_check.
module http_request_host_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hrhe_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;   // [7:0] data_byte
  logic                in_tlast = 1'b0; // last_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;       // [7:0] out_byte, [9:8] status
  logic [TagW-1:0]     out_tuser;       // [1:0] field_tag

  int fail_count;
  int outstanding;
  int result_count;
  int found_count;
  int reject_count;
  int cycle_no = 0;

  item_t      request_stream[$];
  logic [7:0] req_bytes[$];

  string header_names[8] = '{"Accept", "Hos", "Hostt", "host", "Ho", "X-Id", "Host ", ""};

  http_request_host_extractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  http_request_host_extractor_check checker_inst (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .result_count (result_count),
    .found_count  (found_count),
    .reject_count (reject_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // The receiver stalls at random with a chance of 13 in a hundred, except in one quiet stretch.
  always @(negedge clk) begin
    if (cycle_no >= 600 && cycle_no < 1000) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 13);
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("http_request_host_extractor_test failed");
    $finish;
  end

  function automatic void put_byte(input logic [7:0] b);
    req_bytes.push_back(b);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  // Moves the request under construction into the stream, marking its final byte.
  function automatic void close_request();
    item_t it;
    for (int i = 0; i < req_bytes.size(); i++) begin
      it.data_byte = req_bytes[i];
      it.last_byte = (i == req_bytes.size() - 1);
      request_stream.push_back(it);
    end
    req_bytes.delete();
  endfunction

  // Any byte that is not whitespace.
  function automatic logic [7:0] solid_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b inside {ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr});
    return b;
  endfunction

  // Any byte that does not end a header line.
  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b inside {ChNul, ChLf, ChCr});
    return b;
  endfunction

  // Any byte that neither ends a header line nor is a colon.
  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do b = value_byte();
    while (b == ChColon);
    return b;
  endfunction

  function automatic logic [7:0] gap_byte();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChVt;
      default: return ChFf;
    endcase
  endfunction

  function automatic void put_line_break(input bit allow_nul);
    case ($urandom_range(allow_nul ? 3 : 2))
      0: begin
        put_byte(ChCr);
        put_byte(ChLf);
      end
      1: put_byte(ChLf);
      2: put_byte(ChCr);
      default: put_byte(ChNul);
    endcase
  endfunction

  // A request line, some headers and usually a Host line with random content;
  // optionally cut short at a random byte.
  function automatic void build_request(input bit cut_short);
    int n;
    int cut;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++)
      put_byte(($urandom_range(7) == 0) ? solid_byte() : 8'($urandom_range(8'h41, 8'h5A)));
    n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) put_byte(gap_byte());
    put_byte(8'h2F);
    n = $urandom_range(0, 7);
    for (int k = 0; k < n; k++) put_byte(solid_byte());
    if ($urandom_range(1)) begin
      put_str(" HTTP/1.1");
    end else begin
      put_byte(gap_byte());
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) put_byte(solid_byte());
    end
    put_line_break(1'b0);

    // Header lines that must not match.
    n = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: put_line_break(1'b1);
        1: begin
          for (int j = $urandom_range(1, 5); j > 0; j--) put_byte(name_byte());
          put_line_break(1'b1);
        end
        default: begin
          put_str(header_names[$urandom_range(7)]);
          put_byte(ChColon);
          for (int j = $urandom_range(0, 4); j > 0; j--) put_byte(value_byte());
          put_line_break(1'b1);
        end
      endcase
    end

    // The Host line, ended by a line break or by the last byte.
    if ($urandom_range(9) != 0) begin
      put_str("Host:");
      for (int j = $urandom_range(0, 2); j > 0; j--) put_byte(gap_byte());
      for (int j = $urandom_range(0, 6); j > 0; j--) put_byte(value_byte());
      if ($urandom_range(1)) begin
        put_line_break(1'b1);
        for (int j = $urandom_range(0, 3); j > 0; j--) put_byte(8'($urandom_range(255)));
      end
    end

    if (cut_short) begin
      cut = $urandom_range(1, req_bytes.size());
      while (req_bytes.size() > cut) void'(req_bytes.pop_back());
    end
    close_request();
  endfunction

  initial begin
    int idx;
    int roll;

    // Directed requests.
    // Leading whitespace, then a byte that only rearms the parser.
    put_byte(ChTab);
    put_byte(8'hFF);
    close_request();
    // Newline ending the method.
    put_byte(8'h80);
    put_byte(ChCr);
    put_byte(ChNul);
    close_request();
    // Newline among the blanks after the method.
    put_byte(8'hFF);
    put_byte(ChSpace);
    put_byte(ChLf);
    close_request();
    // Newline ending the path.
    put_str("A");
    put_byte(ChSpace);
    put_str("/");
    put_byte(ChCr);
    close_request();
    // Empty host value ended by NUL, then a trailing byte.
    put_str("A");
    put_byte(ChVt);
    put_str("/");
    put_byte(ChFf);
    put_byte(ChLf);
    put_str("Host:");
    put_byte(ChSpace);
    put_byte(ChNul);
    put_byte(8'h7F);
    close_request();

    // Random requests: mostly well formed, some cut short, some noise.
    while (request_stream.size() < 1150) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        build_request(1'b0);
      end else if (roll < 85) begin
        build_request(1'b1);
      end else begin
        for (int j = $urandom_range(1, 10); j > 0; j--) put_byte(8'($urandom_range(255)));
        close_request();
      end
    end

    // Hold reset, then release it on a falling clock edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Feed the stream; the sender idles at random outside the same quiet stretch.
    idx = 0;
    @(negedge clk);
    while (idx < request_stream.size()) begin
      if ((cycle_no < 600 || cycle_no >= 1000) && $urandom_range(99) < 13) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= request_stream[idx].data_byte;
        in_tlast <= request_stream[idx].last_byte;
        do @(posedge clk);
        while (!in_tready);
        idx++;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b0;

    // Drain the results, then let the pipeline settle.
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d request bytes and checked %0d results.",
             request_stream.size(), result_count);
    $display("Requests decided: %0d with a host found, %0d rejected.",
             found_count, reject_count);
    if (fail_count == 0) begin
      $display("http_request_host_extractor_test passed");
    end else begin
      $display("%0d mismatches in total.", fail_count);
      $display("http_request_host_extractor_test failed");
    end
    $finish;
  end

endmodule
